// File: hdl/srp_pkg.sv
// Shared types, phase codes, register indexes and the ramp period table
// for the stepper ramp profile unit. No dependencies.
`default_nettype none

package srp_pkg;

  // Motion phase codes
  localparam logic [2:0] PH_ACC    = 3'd0;
  localparam logic [2:0] PH_WALK   = 3'd1;
  localparam logic [2:0] PH_RUN    = 3'd2;
  localparam logic [2:0] PH_DEC    = 3'd3;
  localparam logic [2:0] PH_STEADY = 3'd4;

  // Motor enable command codes
  localparam logic [1:0] EN_NONE = 2'd0;
  localparam logic [1:0] EN_ON   = 2'd1;
  localparam logic [1:0] EN_OFF  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_STEPS      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH_TIME = 8'd1;

  // Stored ramp table; entries past its end repeat the last value
  localparam int unsigned ROM_STORED = 285;
  localparam int unsigned ROM_AW     = $clog2(ROM_STORED);

  localparam logic [11:0] RAMP_ROM [0:ROM_STORED-1] = '{
    12'd2600,12'd2600,12'd2600,12'd2599,12'd2598,12'd2597,12'd2596,12'd2595,12'd2593,
    12'd2591,12'd2590,12'd2588,12'd2585,12'd2583,
    12'd2580,12'd2578,12'd2575,12'd2572,12'd2569,12'd2565,12'd2562,12'd2558,12'd2554,
    12'd2550,12'd2546,12'd2542,12'd2537,12'd2533,12'd2528,12'd2523,12'd2518,12'd2513,
    12'd2508,12'd2502,12'd2497,12'd2491,
    12'd2485,12'd2479,12'd2473,12'd2467,12'd2460,12'd2454,12'd2447,12'd2440,12'd2433,
    12'd2426,12'd2419,12'd2412,12'd2404,12'd2397,12'd2389,12'd2381,12'd2373,12'd2365,
    12'd2357,12'd2349,12'd2340,12'd2332,
    12'd2323,12'd2315,12'd2306,12'd2297,12'd2288,12'd2279,12'd2270,12'd2260,12'd2251,
    12'd2241,12'd2232,12'd2222,12'd2212,12'd2202,12'd2192,12'd2182,12'd2172,12'd2162,
    12'd2152,12'd2141,12'd2131,12'd2120,
    12'd2109,12'd2099,12'd2088,12'd2077,12'd2066,12'd2055,12'd2044,12'd2033,12'd2021,
    12'd2010,12'd1999,12'd1987,12'd1976,12'd1964,12'd1952,12'd1941,12'd1929,12'd1917,
    12'd1905,12'd1893,12'd1881,12'd1869,
    12'd1857,12'd1845,12'd1833,12'd1820,12'd1808,12'd1796,12'd1783,12'd1771,12'd1758,
    12'd1746,12'd1733,12'd1720,12'd1708,12'd1695,12'd1682,12'd1670,12'd1657,12'd1644,
    12'd1631,12'd1618,12'd1605,12'd1593,
    12'd1580,12'd1567,12'd1554,12'd1541,12'd1528,12'd1515,12'd1501,12'd1488,12'd1475,
    12'd1462,12'd1449,12'd1436,12'd1423,12'd1410,12'd1397,12'd1383,12'd1370,12'd1357,
    12'd1344,12'd1331,12'd1318,12'd1304,
    12'd1291,12'd1278,12'd1265,12'd1252,12'd1239,12'd1226,12'd1213,12'd1200,12'd1186,
    12'd1173,12'd1160,12'd1147,12'd1134,12'd1121,12'd1108,12'd1096,12'd1083,12'd1070,
    12'd1057,12'd1044,12'd1031,12'd1019,
    12'd1006,12'd993,12'd980,12'd968,12'd955,12'd943,12'd930,12'd918,12'd905,12'd893,
    12'd881,12'd868,12'd856,12'd844,12'd832,12'd820,12'd808,12'd796,12'd784,12'd772,
    12'd760,12'd749,12'd737,12'd725,12'd714,12'd702,12'd691,
    12'd680,12'd668,12'd657,12'd646,12'd635,12'd624,12'd613,12'd602,12'd592,12'd581,
    12'd570,12'd560,12'd549,12'd539,12'd529,12'd519,12'd509,12'd499,12'd489,12'd479,
    12'd469,12'd460,12'd450,12'd441,12'd431,12'd422,12'd413,
    12'd404,12'd395,12'd386,12'd378,12'd369,12'd360,12'd352,12'd344,12'd336,12'd328,
    12'd320,12'd312,12'd304,12'd297,12'd289,12'd282,12'd275,12'd268,12'd261,12'd254,
    12'd247,12'd241,12'd234,12'd228,12'd222,12'd216,12'd210,
    12'd204,12'd199,12'd193,12'd188,12'd183,12'd178,12'd173,12'd168,12'd164,12'd159,
    12'd155,12'd151,12'd147,12'd143,12'd139,12'd136,12'd132,12'd129,12'd126,12'd123,
    12'd121,12'd118,12'd116,12'd113,12'd111,12'd110,12'd108,
    12'd106,12'd105,12'd104,12'd103,12'd102,12'd101,12'd101,12'd101,12'd100
  };

  // Table read with the index held at the last stored entry
  function automatic logic [11:0] ramp_lookup(input logic [15:0] idx);
    logic [15:0] last;
    last = 16'(ROM_STORED - 1);
    if (idx >= last) begin
      ramp_lookup = RAMP_ROM[ROM_STORED-1];
    end else begin
      ramp_lookup = RAMP_ROM[idx[ROM_AW-1:0]];
    end
  endfunction

  // Control state carried from pass to pass
  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] counter;
    logic        running;
    logic [11:0] period;
    logic        dir;
  } srp_state_t;

  // One result item
  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  enable_cmd;
    logic [11:0] pulse_low_time;
    logic [11:0] step_period;
    logic        move_dir;
    logic        is_running;
  } srp_result_t;

endpackage

`default_nettype wire

// File: hdl/srp_pass_core.sv
// Next-state and result logic for one control loop pass of the ramp unit.
// Depends on srp_pkg for the state and result types and the ramp table.
`default_nettype none

module srp_pass_core #(
  parameter int unsigned RAMP_STEPS = 285
) (
  input  srp_pkg::srp_state_t  state,
  input  logic                 button_up,
  input  logic                 button_down,
  input  logic                 limit_up,
  input  logic                 limit_down,
  input  logic [15:0]          walk_steps,
  input  logic [6:0]           pulse_high_time,
  output srp_pkg::srp_state_t  state_next,
  output srp_pkg::srp_result_t result
);

  localparam logic [15:0] RampLast = 16'(RAMP_STEPS - 1);

  logic [2:0]  phase_btn;
  logic        dir_btn;
  logic [2:0]  phase_wind;
  logic        btn_sel;
  logic        limit_sel;
  logic        dir_sel;
  logic [15:0] cnt_inc;
  logic [15:0] cnt_dec;
  logic [15:0] rom_idx;
  logic [15:0] rom_idx_sat;
  logic [11:0] rom_data;
  logic [1:0]  enable;
  logic [11:0] per;

  // Phase after releasing or hitting a limit
  always_comb begin
    case (state.phase)
      srp_pkg::PH_ACC, srp_pkg::PH_RUN: phase_wind = srp_pkg::PH_DEC;
      srp_pkg::PH_WALK:                 phase_wind = srp_pkg::PH_STEADY;
      default:                          phase_wind = state.phase;
    endcase
  end

  // Button handling: up wins over down
  assign btn_sel   = button_up | button_down;
  assign limit_sel = button_up ? limit_up : limit_down;
  assign dir_sel   = ~button_up;

  always_comb begin
    phase_btn = state.phase;
    dir_btn   = state.dir;
    if (!btn_sel) begin
      phase_btn = phase_wind;
    end else if (!limit_sel && !state.running) begin
      dir_btn   = dir_sel;
      phase_btn = srp_pkg::PH_WALK;
    end else if (limit_sel && state.running) begin
      phase_btn = phase_wind;
    end
  end

  assign cnt_inc = state.counter + 16'd1;
  assign cnt_dec = (state.counter != 16'd0) ? state.counter - 16'd1 : 16'd0;

  // One shared ramp table read, index saturated to the last ramp entry
  always_comb begin
    case (phase_btn)
      srp_pkg::PH_ACC: rom_idx = state.counter;
      srp_pkg::PH_RUN: rom_idx = cnt_dec;
      srp_pkg::PH_DEC: rom_idx = cnt_dec;
      default:         rom_idx = 16'd0;
    endcase
  end

  assign rom_idx_sat = (rom_idx >= RampLast) ? RampLast : rom_idx;
  assign rom_data    = srp_pkg::ramp_lookup(rom_idx_sat);

  // Phase machine step
  always_comb begin
    state_next       = state;
    state_next.phase = phase_btn;
    state_next.dir   = dir_btn;
    enable           = srp_pkg::EN_NONE;
    case (phase_btn)
      srp_pkg::PH_WALK: begin
        state_next.counter = cnt_inc;
        if (cnt_inc == 16'd1) begin
          state_next.running = 1'b1;
          enable             = srp_pkg::EN_ON;
          state_next.period  = rom_data;
        end else if (cnt_inc == walk_steps) begin
          state_next.counter = 16'd0;
          state_next.phase   = srp_pkg::PH_ACC;
        end
      end
      srp_pkg::PH_ACC: begin
        if (state.counter == RampLast) begin
          state_next.phase = srp_pkg::PH_RUN;
        end
        state_next.period  = rom_data;
        state_next.counter = cnt_inc;
      end
      srp_pkg::PH_RUN: begin
        state_next.period = rom_data;
      end
      srp_pkg::PH_DEC: begin
        state_next.counter = cnt_dec;
        if (cnt_dec == 16'd0) begin
          state_next.phase = srp_pkg::PH_STEADY;
        end
        state_next.period = rom_data;
      end
      default: begin
        if (state.running) begin
          state_next.running = 1'b0;
          state_next.period  = 12'd0;
          state_next.counter = 16'd0;
          enable             = srp_pkg::EN_OFF;
        end
      end
    endcase
  end

  // Result fields; low time saturates at zero
  assign per = state_next.running ? state_next.period : 12'd0;

  always_comb begin
    result.is_running  = state_next.running;
    result.move_dir    = state_next.dir;
    result.step_period = per;
    if (per > {5'd0, pulse_high_time}) begin
      result.pulse_low_time = per - {5'd0, pulse_high_time};
    end else begin
      result.pulse_low_time = 12'd0;
    end
    result.enable_cmd = enable;
    result.phase      = state_next.phase;
  end

endmodule

`default_nettype wire

// File: hdl/stepper_ramp_profile_unit.sv
// Top level of the stepper ramp profile unit: stream ports, config registers,
// input and result registers. Depends on srp_pkg and srp_pass_core.
`default_nettype none

// Each input item is one control loop pass: button and limit samples in,
// one result item out (running flag, direction, step period from the ramp
// table, pulse low time, enable command, phase). The unit takes one item per
// clock cycle while the output side is not stalled. An item is captured in an
// input register and evaluated by the pass logic into a result register, from
// which its result is presented once the output side has room. The ramp
// table read and the phase/counter update sit in that one pass logic stage.
// Configuration writes (index 0 walk_steps, 1 pulse_high_time) are always
// ready and take effect on the next pass; unknown indexes are ignored.
module stepper_ramp_profile_unit #(
  parameter int unsigned RAMP_STEPS = 285
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] button_up, [1] button_down, [2] limit_up, [3] limit_down
  input  logic [7:0]                     s_tdata,
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] is_running, [1] move_dir, [13:2] step_period,
  // [25:14] pulse_low_time, [27:26] enable_cmd, [30:28] phase
  output logic [31:0]                    m_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic                 in_valid;
  logic [3:0]           in_bits;
  logic                 out_valid;
  srp_pkg::srp_result_t out_res;
  logic [15:0]          walk_steps;
  logic [6:0]           pulse_high_time;
  srp_pkg::srp_state_t  state;
  srp_pkg::srp_state_t  state_next;
  srp_pkg::srp_result_t result;
  logic                 out_free;
  logic                 fire;

  // Flow control
  assign out_free  = ~out_valid | m_tready;
  assign fire      = in_valid & out_free;
  assign s_tready  = ~in_valid | fire;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_steps      <= 16'd800;
      pulse_high_time <= 7'd50;
    end else if (cfg_valid) begin
      if (cfg_index == srp_pkg::REG_WALK_STEPS) begin
        walk_steps <= cfg_data;
      end else if (cfg_index == srp_pkg::REG_PULSE_HIGH_TIME) begin
        pulse_high_time <= cfg_data[6:0];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_bits <= s_tdata[3:0];
    end
  end

  // Pass logic
  srp_pass_core #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_core (
    .state           (state),
    .button_up       (in_bits[0]),
    .button_down     (in_bits[1]),
    .limit_up        (in_bits[2]),
    .limit_down      (in_bits[3]),
    .walk_steps      (walk_steps),
    .pulse_high_time (pulse_high_time),
    .state_next      (state_next),
    .result          (result)
  );

  // Control state, updated once per evaluated item
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase   <= srp_pkg::PH_STEADY;
      state.counter <= 16'd0;
      state.running <= 1'b0;
      state.period  <= 12'd0;
      state.dir     <= 1'b0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};

endmodule

`default_nettype wire
